### sv/csf_pkg.sv
// Shared types and constants of the CSV field splitter.
// Used by the parser, the emitter, the top level and the checker.
package csf_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] LF_BYTE     = 8'h0A;
  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam int         MAX_RESULTS = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last_byte;
  } csf_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       field_empty;
    logic       field_end;
    logic       record_end;
    logic       field_overflow;
  } csf_out_t;

  typedef struct packed {
    logic start;
    logic first_q;
    logic last_q;
    logic ovf;
    logic rec;
    logic tail;
  } csf_job_t;

endpackage

### sv/csf_parser.sv
// Byte parser of the CSV field splitter: quote parity, line ends, separator register.
// Writes field bytes to the emitter's store and hands it one job per closing byte.
// Depends on csf_pkg.
module csf_parser #(
  parameter int FIELD_DEPTH = 64,
  parameter int LEN_W       = 7,
  parameter int ADDR_W      = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  csf_pkg::csf_in_t  in_req,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output csf_pkg::csf_job_t job,
  output logic [LEN_W-1:0]  job_len
);
  import csf_pkg::*;

  logic [7:0]       sep_r;
  logic [LEN_W-1:0] len_r, len_nxt, len_add;
  logic             inq_r, inq_nxt, inq_tog;
  logic             swallow_r, swallow_nxt;
  logic             rhc_r, rhc_nxt, rhc_add;
  logic             ovf_r, ovf_nxt, ovf_add;
  logic             fq_r, fq_add;
  logic             lq_r, lq_add;
  logic             is_q, is_lf, is_cr, handled, add, close, sep_cl, room, last;

  always_comb begin
    last    = in_req.is_last_byte;
    is_q    = in_req.data_byte == QUOTE_BYTE;
    is_lf   = in_req.data_byte == LF_BYTE;
    is_cr   = in_req.data_byte == CR_BYTE;
    handled = swallow_r && is_lf;
    add     = 1'b0;
    close   = 1'b0;
    sep_cl  = 1'b0;
    inq_tog = inq_r;
    if (handled) begin
      add = inq_r;
    end else if (is_lf || is_cr) begin
      if (inq_r) begin
        add = 1'b1;
      end else begin
        close = 1'b1;
      end
    end else if (is_q) begin
      inq_tog = !inq_r;
      add     = 1'b1;
    end else if (in_req.data_byte == sep_r && !inq_r) begin
      close  = 1'b1;
      sep_cl = 1'b1;
    end else begin
      add = 1'b1;
    end

    room    = len_r < LEN_W'(FIELD_DEPTH);
    len_add = (add && room) ? len_r + LEN_W'(1) : len_r;
    ovf_add = ovf_r | (add & !room);
    fq_add  = (add && room && len_r == '0) ? is_q : fq_r;
    lq_add  = (add && room) ? is_q : lq_r;
    rhc_add = rhc_r | add;

    wr_en   = accept && add && room;
    wr_addr = len_r[ADDR_W-1:0];
    wr_data = in_req.data_byte;

    job.start   = accept && (close || (last && rhc_add));
    job.first_q = fq_add;
    job.last_q  = lq_add;
    job.ovf     = ovf_add;
    job.rec     = !sep_cl;
    job.tail    = sep_cl && last;
    job_len     = len_add;

    len_nxt     = (close || last) ? '0 : len_add;
    ovf_nxt     = (close || last) ? 1'b0 : ovf_add;
    rhc_nxt     = last ? 1'b0 : (close ? sep_cl : rhc_add);
    inq_nxt     = last ? 1'b0 : inq_tog;
    swallow_nxt = last ? 1'b0 : (!handled && is_cr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r     <= SEP_RESET;
      len_r     <= '0;
      inq_r     <= 1'b0;
      swallow_r <= 1'b0;
      rhc_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
      if (accept) begin
        len_r     <= len_nxt;
        inq_r     <= inq_nxt;
        swallow_r <= swallow_nxt;
        rhc_r     <= rhc_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fq_r <= fq_add;
      lq_r <= lq_add;
    end
  end

endmodule

### sv/csf_emitter.sv
// Field store and emitter of the CSV field splitter.
// Holds the open field in a memory with two read ports, decodes quotes on read-out
// and drives the output register. Depends on csf_pkg.
module csf_emitter #(
  parameter int FIELD_DEPTH = 64,
  parameter int LEN_W       = 7,
  parameter int ADDR_W      = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  csf_pkg::csf_job_t job,
  input  logic [LEN_W-1:0]  job_len,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output csf_pkg::csf_out_t out_req
);
  import csf_pkg::*;

  localparam int IDX_W     = $clog2(FIELD_DEPTH + 2);
  localparam bit CAN_TRUNC = FIELD_DEPTH >= MAX_RESULTS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_EMPTY = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;

  logic [7:0] mem [FIELD_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, hi_r, hi_nxt;
  logic             strip_r, strip_nxt, rec_r, rec_nxt, ovf_r, ovf_nxt, tail_r, tail_nxt;
  logic             out_valid_r, out_valid_nxt;
  csf_out_t         out_req_r, out_req_nxt, load_val;
  logic [7:0]       rd_a_r, rd_b_r;

  logic [IDX_W-1:0] n_x, lo_x, hi_x, nidx, rd_idx, rd_idx_b;
  logic             strip_x, trunc_x, can_load, pair, is_end, load, rd_en;

  always_comb begin
    n_x     = IDX_W'(job_len);
    strip_x = n_x > IDX_W'(1) && job.first_q && job.last_q;
    trunc_x = CAN_TRUNC && job.tail && !strip_x && n_x == IDX_W'(MAX_RESULTS);
    lo_x    = strip_x ? IDX_W'(1) : '0;
    hi_x    = strip_x ? n_x - IDX_W'(1) : (trunc_x ? IDX_W'(MAX_RESULTS - 1) : n_x);

    can_load = !out_valid_r || out_ready;
    pair     = strip_r && rd_a_r == QUOTE_BYTE && (idx_r + IDX_W'(1) < hi_r)
               && rd_b_r == QUOTE_BYTE;
    nidx     = idx_r + (pair ? IDX_W'(2) : IDX_W'(1));
    is_end   = nidx >= hi_r;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    hi_nxt    = hi_r;
    strip_nxt = strip_r;
    rec_nxt   = rec_r;
    ovf_nxt   = ovf_r;
    tail_nxt  = tail_r;
    load      = 1'b0;
    rd_en     = 1'b0;
    load_val  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (job.start) begin
          idx_nxt   = lo_x;
          hi_nxt    = hi_x;
          strip_nxt = strip_x;
          rec_nxt   = job.rec;
          ovf_nxt   = job.ovf | trunc_x;
          tail_nxt  = job.tail;
          state_nxt = (lo_x >= hi_x) ? S_EMPTY : S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_en     = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (can_load) begin
          load     = 1'b1;
          load_val = '{out_char: rd_a_r, field_empty: 1'b0, field_end: is_end,
                       record_end: is_end & rec_r, field_overflow: is_end & ovf_r};
          if (is_end) begin
            state_nxt = tail_r ? S_TAIL : S_IDLE;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = nidx;
          end
        end
      end
      S_EMPTY: begin
        if (can_load) begin
          load      = 1'b1;
          load_val  = '{out_char: 8'h00, field_empty: 1'b1, field_end: 1'b1,
                        record_end: rec_r, field_overflow: ovf_r};
          state_nxt = tail_r ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (can_load) begin
          load      = 1'b1;
          load_val  = '{out_char: 8'h00, field_empty: 1'b1, field_end: 1'b1,
                        record_end: 1'b1, field_overflow: 1'b0};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_idx        = (state_r == S_DATA) ? nidx : idx_r;
    rd_idx_b      = rd_idx + IDX_W'(1);
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_req_nxt   = load ? load_val : out_req_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_idx[ADDR_W-1:0]];
      rd_b_r <= mem[rd_idx_b[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    hi_r      <= hi_nxt;
    strip_r   <= strip_nxt;
    rec_r     <= rec_nxt;
    ovf_r     <= ovf_nxt;
    tail_r    <= tail_nxt;
    out_req_r <= out_req_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

### sv/csv_field_splitter.sv
// CSV field splitter: takes one text byte per request and returns decoded fields byte by byte.
// A byte that does not close a field is taken without holding off input. A byte that closes a field
// with content holds off input while the emitter starts the field store read in its issue state and
// then emits the results, the two-port read of the field store giving one decoded byte per cycle
// while the output does not stall; a field that decodes to nothing gives one empty result, and a
// final separator adds one more empty result for the empty field it closes.
// Instantiates csf_parser and csf_emitter; depends on csf_pkg.
module csv_field_splitter #(
  parameter int FIELD_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csf_pkg::csf_in_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output csf_pkg::csf_out_t out_req,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import csf_pkg::*;

  localparam int LEN_W  = $clog2(FIELD_DEPTH + 1);
  localparam int ADDR_W = $clog2(FIELD_DEPTH);

  logic              accept, busy, wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  csf_job_t          job;
  logic [LEN_W-1:0]  job_len;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  csf_parser #(
    .FIELD_DEPTH(FIELD_DEPTH),
    .LEN_W      (LEN_W),
    .ADDR_W     (ADDR_W)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job      (job),
    .job_len  (job_len)
  );

  csf_emitter #(
    .FIELD_DEPTH(FIELD_DEPTH),
    .LEN_W      (LEN_W),
    .ADDR_W     (ADDR_W)
  ) u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job      (job),
    .job_len  (job_len),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req  (out_req)
  );

endmodule

### sv/csf_checker.sv
// Port-level checker for the CSV field splitter, bound to the top level.
// Depends on csf_pkg.
module csf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input csf_pkg::csf_out_t out_req
);
  import csf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("result changed while stalled");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.field_empty |-> out_req.field_end && out_req.out_char == 8'h00)
    else $error("empty field result is malformed");

  a_rec_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.record_end |-> out_req.field_end)
    else $error("record end without field end");

  a_ovf_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.field_overflow |-> out_req.field_end)
    else $error("overflow flag without field end");

endmodule

bind csv_field_splitter csf_checker u_chk (.*);

### verif/csf_checker_pkg.sv
`timescale 1ns / 100ps
// Predictor and result checker for the CSV field splitter testbench.
// Depends on csf_pkg for the request and result types.
package csf_checker_pkg;
  import csf_pkg::*;

  localparam int FIELD_DEPTH = 64;

  class csv_field_checker;
    logic [7:0] separator;
    logic [7:0] field_bytes [FIELD_DEPTH];
    int         field_len;
    bit         quoted;
    bit         skip_lf;
    bit         record_open;
    bit         dropped;
    csf_out_t   decoded_due[$];
    int         errors;

    function new();
      separator   = SEP_RESET;
      field_len   = 0;
      quoted      = 0;
      skip_lf     = 0;
      record_open = 0;
      dropped     = 0;
      errors      = 0;
    endfunction

    function void keep_byte(logic [7:0] b);
      if (field_len < FIELD_DEPTH) begin
        field_bytes[field_len] = b;
        field_len++;
      end else begin
        dropped = 1;
      end
      record_open = 1;
    endfunction

    // Decodes the open field into the queue of due results and returns how many it added.
    function int close_field(bit rec, int limit);
      logic [7:0] text[$];
      int         lo;
      int         hi;
      int         i;
      bit         ovf;
      csf_out_t   r;
      ovf = dropped;
      lo  = 0;
      hi  = field_len;
      if (field_len > 1 && field_bytes[0] == QUOTE_BYTE &&
          field_bytes[field_len - 1] == QUOTE_BYTE) begin
        lo = 1;
        hi = field_len - 1;
      end
      i = lo;
      while (i < hi) begin
        text.insert(text.size(), field_bytes[i]);
        if (lo == 1 && field_bytes[i] == QUOTE_BYTE && i + 1 < hi &&
            field_bytes[i + 1] == QUOTE_BYTE) begin
          i += 2;
        end else begin
          i++;
        end
      end
      if (text.size() > limit) begin
        ovf = 1;
        while (text.size() > limit) void'(text.pop_back());
      end
      if (text.size() == 0) begin
        r.out_char       = 8'h00;
        r.field_empty    = 1'b1;
        r.field_end      = 1'b1;
        r.record_end     = rec;
        r.field_overflow = ovf;
        decoded_due.insert(decoded_due.size(), r);
      end else begin
        for (int k = 0; k < text.size(); k++) begin
          r.out_char       = text[k];
          r.field_empty    = 1'b0;
          r.field_end      = (k == text.size() - 1);
          r.record_end     = r.field_end & rec;
          r.field_overflow = r.field_end & ovf;
          decoded_due.insert(decoded_due.size(), r);
        end
      end
      field_len = 0;
      dropped   = 0;
      if (rec) record_open = 0;
      return (text.size() == 0) ? 1 : text.size();
    endfunction

    function void note_request(csf_in_t req);
      logic [7:0] b;
      bit         last;
      bit         done;
      int         made;
      b    = req.data_byte;
      last = req.is_last_byte;
      done = 0;
      made = 0;
      if (skip_lf) begin
        skip_lf = 0;
        if (b == LF_BYTE) begin
          if (quoted) keep_byte(b);
          done = 1;
        end
      end
      if (!done) begin
        if (b == LF_BYTE) begin
          if (quoted) keep_byte(b);
          else made = close_field(1, MAX_RESULTS);
        end else if (b == CR_BYTE) begin
          if (quoted) keep_byte(b);
          else made = close_field(1, MAX_RESULTS);
          skip_lf = 1;
        end else if (b == QUOTE_BYTE) begin
          quoted = !quoted;
          keep_byte(b);
        end else if (b == separator && !quoted) begin
          made = close_field(0, last ? MAX_RESULTS - 1 : MAX_RESULTS);
          record_open = 1;
        end else begin
          keep_byte(b);
        end
      end
      if (last) begin
        if (record_open) made += close_field(1, MAX_RESULTS - made);
        field_len   = 0;
        dropped     = 0;
        quoted      = 0;
        skip_lf     = 0;
        record_open = 0;
      end
    endfunction

    function void report(string what, csf_out_t want, csf_out_t got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s: expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_result(csf_out_t got);
      csf_out_t want;
      if (decoded_due.size() == 0) begin
        want = '0;
        report("result with none due", want, got);
      end else begin
        want = decoded_due.pop_front();
        // The character is meaningless on an empty field.
        if (got.field_empty !== want.field_empty || got.field_end !== want.field_end ||
            got.record_end !== want.record_end ||
            got.field_overflow !== want.field_overflow ||
            (!want.field_empty && got.out_char !== want.out_char))
          report("result mismatch", want, got);
      end
    endfunction
  endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the CSV field splitter testbench: clock, reset, request and result drivers.
// Depends on csf_pkg, csf_checker_pkg and the csv_field_splitter RTL.
module testbench;
  import csf_pkg::*;
  import csf_checker_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int PHASE_ITEMS = 35;

  typedef enum int {
    END_LF, END_CR, END_CRLF, END_LF_LAST, END_SEP_LAST, END_TEXT_LAST
  } rec_end_e;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  csf_in_t    in_req;
  logic       out_valid;
  logic       out_ready;
  csf_out_t   out_req;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  csv_field_checker board = new();
  logic [7:0] sep_now;
  bit         send_idle;
  bit         rx_idle;
  int         items_sent;
  int         rx_count;
  int         quiet = 0;

  csv_field_splitter #(.FIELD_DEPTH(FIELD_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_request(in_req);
      if (out_valid && out_ready) board.check_result(out_req);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            = 1'b1;
    in_req.data_byte    = b;
    in_req.is_last_byte = last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CR_BYTE || c == LF_BYTE || c == QUOTE_BYTE || c == sep_now);
    return c;
  endfunction

  task automatic send_field(input int len, input bit with_quotes);
    int pick;
    if (with_quotes) send_byte(QUOTE_BYTE, 0);
    for (int i = 0; i < len; i++) begin
      pick = with_quotes ? $urandom_range(0, 9) : 9;
      case (pick)
        0: begin
          send_byte(QUOTE_BYTE, 0);
          send_byte(QUOTE_BYTE, 0);
        end
        1: send_byte(sep_now, 0);
        2: send_byte(CR_BYTE, 0);
        3: send_byte(LF_BYTE, 0);
        default: send_byte(plain_byte(), 0);
      endcase
    end
    if (with_quotes) send_byte(QUOTE_BYTE, 0);
  endtask

  task automatic send_record();
    int       nf;
    int       len;
    rec_end_e how;
    nf        = $urandom_range(1, 4);
    send_idle = $urandom_range(0, 2) != 0;
    for (int f = 0; f < nf; f++) begin
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 6);
      send_field(len, $urandom_range(0, 2) == 0);
      if (f < nf - 1) send_byte(sep_now, 0);
    end
    how = rec_end_e'($urandom_range(0, 5));
    case (how)
      END_LF:       send_byte(LF_BYTE, 0);
      END_CR:       send_byte(CR_BYTE, 0);
      END_CRLF: begin
        send_byte(CR_BYTE, 0);
        send_byte(LF_BYTE, 0);
      end
      END_LF_LAST:  send_byte(LF_BYTE, 1);
      END_SEP_LAST: send_byte(sep_now, 1);
      default:      send_byte(plain_byte(), 1);
    endcase
  endtask

  task automatic random_phase(input bit long_final_sep);
    int stop_at;
    stop_at = items_sent + PHASE_ITEMS;
    if (long_final_sep) begin
      // A long field closed by a final separator can lose its last byte.
      send_idle = 1'b0;
      send_field($urandom_range(62, 68), 1'($urandom_range(0, 1)));
      send_byte(sep_now, 1);
    end
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        send_record();
      end
    end
  endtask

  task automatic write_separator(input logic [7:0] value);
    @(negedge clk) in_valid = 1'b0;
    while (board.decoded_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk) cfg_we = 1'b0;
    board.separator = value;
    sep_now         = value;
  endtask

  initial begin
    out_ready = 1'b0;
    rx_count  = 0;
    rx_idle   = 1'b0;
    @(posedge rst_n);
    forever begin
      int gap;
      if (rx_count % 24 == 0) rx_idle = 1'($urandom_range(0, 1));
      gap = rx_idle ? $urandom_range(0, 18) : 0;
      if (rx_count == 60) gap = LONG_HOLD;
      if (gap > 0) begin
        @(negedge clk) out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      rx_count++;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = SEP_RESET;
    sep_now    = SEP_RESET;
    send_idle  = 1'b0;
    items_sent = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // A plain field, an empty field, a quoted quote, and CRLF as one line end.
    send_byte("x", 0);
    send_byte(SEP_RESET, 0);
    send_byte(SEP_RESET, 0);
    repeat (4) send_byte(QUOTE_BYTE, 0);
    send_byte(CR_BYTE, 0);
    send_byte(LF_BYTE, 0);
    // Separator and CRLF kept inside quotes.
    send_idle = 1'b1;
    send_byte(QUOTE_BYTE, 0);
    send_byte(SEP_RESET, 0);
    send_byte(CR_BYTE, 0);
    send_byte(LF_BYTE, 0);
    send_byte(QUOTE_BYTE, 0);
    send_byte(LF_BYTE, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h00, 0);
    send_byte(LF_BYTE, 0);
    // Two quotes decode to nothing; a final separator closes two fields.
    send_byte(QUOTE_BYTE, 0);
    send_byte(QUOTE_BYTE, 0);
    send_byte(SEP_RESET, 0);
    send_byte("q", 0);
    send_byte(SEP_RESET, 1);
    send_byte(LF_BYTE, 1);
    send_byte(QUOTE_BYTE, 1);

    random_phase(1'b0);
    write_separator(8'h09);
    random_phase(1'b1);
    write_separator(8'hFF);
    random_phase(1'b0);
    write_separator(8'h00);
    random_phase(1'b0);
    write_separator(CR_BYTE);
    random_phase(1'b0);
    write_separator(QUOTE_BYTE);
    random_phase(1'b0);
    write_separator(SEP_RESET);
    random_phase(1'b0);

    @(negedge clk) in_valid = 1'b0;
    while (board.decoded_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
